>>> rtl/core/rdue_pkg.sv
// shared types, codes and crc helper for the register datagram uart engine
package rdue_pkg;

  // line constants
  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  // input opcodes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e_t;

  // frame byte positions
  localparam logic [2:0] POS_SYNC      = 3'd0;
  localparam logic [2:0] POS_NODE      = 3'd1;
  localparam logic [2:0] POS_REG       = 3'd2;
  localparam logic [2:0] POS_DATA_HI   = 3'd3;
  localparam logic [2:0] POS_DATA_MH   = 3'd4;
  localparam logic [2:0] POS_DATA_ML   = 3'd5;
  localparam logic [2:0] POS_DATA_LO   = 3'd6;
  localparam logic [2:0] POS_WRITE_CRC = 3'd7;
  localparam logic [2:0] POS_READ_CRC  = 3'd3;

  // result kinds
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // queued command kinds
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  node_address;
    logic [6:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] reply_data;
  } out_word_t;

  // one unit of work for the back end
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] data;
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // crc-8 over one byte, fed lsb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       top;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      top = c[7];
      c = {c[6:0], 1'b0};
      if (top ^ data[k]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/rdue_front.sv
// front end: accepts words, runs the receive framer, queues commands
module rdue_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rdue_pkg::in_word_t in_word,
  input  rdue_pkg::q_status_t q_status,
  output logic               push_valid,
  output rdue_pkg::cmd_t     push_cmd
);

  logic [2:0]  rx_pos_r, rx_pos_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic [31:0] rx_shift_r, rx_shift_nxt;
  logic        accept;
  logic [7:0]  crc_step;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign crc_step = rdue_pkg::crc_feed(rx_crc_r, in_word.rx_byte);

  // classify the word and update the receive framer
  always_comb begin
    rx_pos_nxt         = rx_pos_r;
    rx_crc_nxt         = rx_crc_r;
    rx_shift_nxt       = rx_shift_r;
    push_valid         = 1'b0;
    push_cmd.kind      = rdue_pkg::CMD_WRITE;
    push_cmd.node      = in_word.node_address;
    push_cmd.reg_addr  = in_word.reg_address;
    push_cmd.data      = in_word.write_data;
    if (accept) begin
      case (rdue_pkg::opcode_e_t'(in_word.opcode))
        rdue_pkg::OP_WRITE: begin
          push_valid    = 1'b1;
          push_cmd.kind = rdue_pkg::CMD_WRITE;
        end
        rdue_pkg::OP_READ: begin
          push_valid    = 1'b1;
          push_cmd.kind = rdue_pkg::CMD_READ;
        end
        rdue_pkg::OP_RX: begin
          if (rx_pos_r == rdue_pkg::POS_SYNC) begin
            // hunting for sync
            if (in_word.rx_byte == rdue_pkg::SYNC_BYTE) begin
              rx_crc_nxt   = rdue_pkg::crc_feed(8'h00, in_word.rx_byte);
              rx_shift_nxt = '0;
              rx_pos_nxt   = rdue_pkg::POS_NODE;
            end
          end else if (rx_pos_r != rdue_pkg::POS_WRITE_CRC) begin
            // frame body
            rx_crc_nxt = crc_step;
            if (rx_pos_r >= rdue_pkg::POS_DATA_HI) begin
              rx_shift_nxt = {rx_shift_r[23:0], in_word.rx_byte};
            end
            rx_pos_nxt = rx_pos_r + 3'd1;
          end else begin
            // crc byte: queue the reply only when it matches
            rx_pos_nxt    = rdue_pkg::POS_SYNC;
            rx_crc_nxt    = '0;
            rx_shift_nxt  = '0;
            push_valid    = (in_word.rx_byte == rx_crc_r);
            push_cmd.kind = rdue_pkg::CMD_REPLY;
            push_cmd.data = rx_shift_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // receive state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_pos_r   <= '0;
      rx_crc_r   <= '0;
      rx_shift_r <= '0;
    end else begin
      rx_pos_r   <= rx_pos_nxt;
      rx_crc_r   <= rx_crc_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

endmodule

>>> rtl/core/rdue_queue.sv
// short command queue between front and back ends
module rdue_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rdue_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output rdue_pkg::cmd_t      head_cmd,
  output rdue_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rdue_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_cmd     = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/rdue_back.sv
// back end: expands queued commands into line bytes or reply words
module rdue_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rdue_pkg::cmd_t      head_cmd,
  input  rdue_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rdue_pkg::out_word_t out_word
);

  logic [2:0]          idx_r, idx_nxt;
  logic [7:0]          crc_r, crc_nxt;
  logic                out_valid_r, out_valid_nxt;
  rdue_pkg::out_word_t out_word_r, out_word_nxt;
  logic                out_free;
  logic                fire;
  logic [7:0]          frame_byte;
  logic [7:0]          line_byte;
  logic [2:0]          last_idx;
  logic                is_last;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = !q_status.empty && out_free;

  // byte at the current frame position
  always_comb begin
    case (idx_r)
      rdue_pkg::POS_SYNC: frame_byte = rdue_pkg::SYNC_BYTE;
      rdue_pkg::POS_NODE: frame_byte = head_cmd.node;
      rdue_pkg::POS_REG: begin
        frame_byte = (head_cmd.kind == rdue_pkg::CMD_WRITE)
                   ? ({1'b0, head_cmd.reg_addr} | rdue_pkg::WRITE_FLAG)
                   : {1'b0, head_cmd.reg_addr};
      end
      rdue_pkg::POS_DATA_HI: frame_byte = head_cmd.data[31:24];
      rdue_pkg::POS_DATA_MH: frame_byte = head_cmd.data[23:16];
      rdue_pkg::POS_DATA_ML: frame_byte = head_cmd.data[15:8];
      rdue_pkg::POS_DATA_LO: frame_byte = head_cmd.data[7:0];
      default:               frame_byte = 8'h00;
    endcase
  end

  assign last_idx  = (head_cmd.kind == rdue_pkg::CMD_WRITE)
                   ? rdue_pkg::POS_WRITE_CRC : rdue_pkg::POS_READ_CRC;
  assign is_last   = (idx_r == last_idx);
  assign line_byte = is_last ? crc_r : frame_byte;

  // sequencer and output register
  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    pop           = 1'b0;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (fire) begin
      case (head_cmd.kind)
        rdue_pkg::CMD_WRITE, rdue_pkg::CMD_READ: begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.kind       = rdue_pkg::KIND_TX;
          out_word_nxt.tx_byte    = line_byte;
          out_word_nxt.last       = is_last;
          out_word_nxt.reply_data = '0;
          if (is_last) begin
            idx_nxt = '0;
            crc_nxt = '0;
            pop     = 1'b1;
          end else begin
            idx_nxt = idx_r + 3'd1;
            crc_nxt = rdue_pkg::crc_feed(crc_r, line_byte);
          end
        end
        rdue_pkg::CMD_REPLY: begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.kind       = rdue_pkg::KIND_REPLY;
          out_word_nxt.tx_byte    = '0;
          out_word_nxt.last       = 1'b1;
          out_word_nxt.reply_data = head_cmd.data;
          pop                     = 1'b1;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_cmd.kind != rdue_pkg::CMD_REPLY
         && (head_cmd.kind == rdue_pkg::CMD_WRITE || head_cmd.kind == rdue_pkg::CMD_READ))
    |=> (out_valid_r && out_word_r.last && idx_r == 3'd0))
    else $error("datagram popped without a last byte");

  a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_status.empty && head_cmd.kind == rdue_pkg::CMD_READ) |-> (idx_r <= 3'd3))
    else $error("read request ran past its crc byte");

  a_reply_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_status.empty && head_cmd.kind == rdue_pkg::CMD_REPLY) |-> (idx_r == 3'd0))
    else $error("reply reached with datagram in progress");

endmodule

>>> rtl/core/register_datagram_uart_engine_top.sv
// top level of the register datagram uart engine
// a command from an accepted word passes through the queue into the output register
// a write goes out as eight line bytes, a read request as four, a good reply as one word;
//   the back end emits one line byte per cycle while out_stall does not hold it
// the front keeps accepting while the command queue has room
// reset (synchronous, active low) empties the queue, clears the receive framer and idles the back end
module register_datagram_uart_engine_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdue_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rdue_pkg::out_word_t out_word
);

  rdue_pkg::q_status_t q_status;
  rdue_pkg::cmd_t      push_cmd;
  rdue_pkg::cmd_t      head_cmd;
  logic                push_valid;
  logic                pop;

  // word intake and receive framer
  rdue_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // command queue
  rdue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // datagram sequencer
  rdue_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
